@@ design/vpa_pkg.sv @@
// Shared constants, types and command structures of the partition allocator.
package vpa_pkg;
  localparam int MemUnits    = 512;
  localparam int FreeEntries = 64;
  localparam int UsedEntries = 64;
  localparam int AddrW = $clog2(MemUnits);
  localparam int LenW  = $clog2(MemUnits) + 1;
  localparam int FIdxW = $clog2(FreeEntries);
  localparam int UIdxW = $clog2(UsedEntries);

  localparam logic [1:0] STRAT_FIRST = 2'd0;
  localparam logic [1:0] STRAT_BEST  = 2'd1;
  localparam logic [1:0] STRAT_WORST = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFIT  = 2'd1;
  localparam logic [1:0] ST_NOADDR = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef struct packed {
    logic clear;
    logic scan_used;
    logic scan_free;
    logic commit;
    logic [FIdxW:0] idx;
  } vpa_cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [AddrW-1:0] addr;
  } vpa_stat_t;
endpackage

@@ design/vpa_if.sv @@
// Valid/ready channel interface carrying the payload of one transaction.
interface vpa_if #(parameter int W = 1) ();
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/vpa_ctrl.sv @@
// Sequencer that steps the datapath through the table scans of one transaction.
module vpa_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  logic out_fire,
  output logic in_ready,
  output logic out_valid,
  output vpa_pkg::vpa_cmd_t cmd
);
  import vpa_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0, S_USED = 3'd1, S_FREE = 3'd2, S_DRAIN = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4, S_OUT = 3'd5;
  logic [2:0] state_r, state_nxt;
  logic [FIdxW:0] idx_r, idx_nxt;
  localparam logic [FIdxW:0] FLast = (FIdxW+1)'(FreeEntries - 1);
  localparam logic [FIdxW:0] ULast = (FIdxW+1)'(UsedEntries - 1);

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    cmd = '0;
    cmd.idx = idx_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.clear = in_fire;
        if (in_fire) begin
          state_nxt = S_USED;
          idx_nxt = '0;
        end
      end
      S_USED: begin
        cmd.scan_used = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == ULast) begin
          state_nxt = S_FREE;
          idx_nxt = '0;
        end
      end
      S_FREE: begin
        cmd.scan_free = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == FLast) begin
          state_nxt = S_DRAIN;
          idx_nxt = '0;
        end
      end
      S_DRAIN: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_fire) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
    end
  end
endmodule

@@ design/vpa_dp.sv @@
// Table RAM, scan comparators and commit logic of the allocator.
module vpa_dp (
  input  logic clk,
  input  logic rst_n,
  input  vpa_pkg::vpa_cmd_t cmd,
  input  logic [1:0] strategy,
  input  logic func,
  input  logic [vpa_pkg::AddrW-1:0] req_size,
  input  logic [vpa_pkg::AddrW-1:0] release_addr,
  output vpa_pkg::vpa_stat_t stat
);
  import vpa_pkg::*;
  logic [FreeEntries-1:0] fv_r;
  logic [UsedEntries-1:0] uv_r;

  logic func_r;
  logic [AddrW-1:0] size_r, addr_r;
  logic [LenW-1:0] rlen_r;
  logic [AddrW:0] rend_r;
  logic uf_r, ff_r, bf_r, lf_r, rf_r, ef_r;
  logic [UIdxW-1:0] uslot_r, uhit_r;
  logic [FIdxW-1:0] fslot_r, best_r, left_r, right_r;
  logic [AddrW-1:0] bstart_r;
  logic [LenW-1:0] blen_r, left_len_r, right_len_r;
  logic [1:0] status_r;
  logic [AddrW-1:0] gaddr_r;

  logic scan_u_r, scan_f_r;
  logic [FIdxW-1:0] sidx_r;

  logic fs_we, fl_we, u_we;
  logic [FIdxW-1:0] f_wa;
  logic [AddrW-1:0] fs_wd;
  logic [LenW-1:0] fl_wd;
  logic [2*AddrW-1:0] u_wd;
  logic [AddrW-1:0] fs_rd;
  logic [LenW-1:0] fl_rd;
  logic [2*AddrW-1:0] u_rd;
  logic [FIdxW-1:0] rfi;
  logic [UIdxW-1:0] rui;

  logic [UIdxW-1:0] ui;
  logic [FIdxW-1:0] fi;
  logic [LenW-1:0] need, clen, nlen;
  logic [AddrW-1:0] cst, ust, ulen, galloc;
  logic cv, uvl, better;

  assign rfi = cmd.idx[FIdxW-1:0];
  assign rui = cmd.idx[UIdxW-1:0];

  vpa_ram #(.W(AddrW), .D(FreeEntries)) u_fs_ram (
    .clk, .we(fs_we), .waddr(f_wa), .wdata(fs_wd), .raddr(rfi), .rdata_r(fs_rd)
  );
  vpa_ram #(.W(LenW), .D(FreeEntries)) u_fl_ram (
    .clk, .we(fl_we), .waddr(f_wa), .wdata(fl_wd), .raddr(rfi), .rdata_r(fl_rd)
  );
  vpa_ram #(.W(2*AddrW), .D(UsedEntries)) u_used_ram (
    .clk, .we(u_we), .waddr(uslot_r), .wdata(u_wd), .raddr(rui), .rdata_r(u_rd)
  );

  // Read data returns in the cycle after the address, so the scan commands are registered to match.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_u_r <= 1'b0;
      scan_f_r <= 1'b0;
      sidx_r <= '0;
    end else begin
      scan_u_r <= cmd.scan_used;
      scan_f_r <= cmd.scan_free;
      sidx_r <= cmd.idx[FIdxW-1:0];
    end
  end

  assign ui = sidx_r[UIdxW-1:0];
  assign fi = sidx_r;
  assign need = {1'b0, size_r} + 1'b1;
  assign cst = fs_rd;
  assign clen = fl_rd;
  assign cv = fv_r[fi];
  assign ust = u_rd[2*AddrW-1:AddrW];
  assign ulen = u_rd[AddrW-1:0];
  assign uvl = uv_r[ui];
  assign nlen = blen_r - need;
  assign galloc = (blen_r == need) ? bstart_r : AddrW'({1'b0, bstart_r} + nlen);
  assign u_wd = {galloc, size_r};

  always_comb begin
    better = 1'b0;
    if (!bf_r) better = 1'b1;
    else if (strategy == STRAT_BEST && clen != blen_r) better = clen < blen_r;
    else if (strategy == STRAT_WORST && clen != blen_r) better = clen > blen_r;
    else better = cst < bstart_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      func_r <= func;
      size_r <= req_size;
      addr_r <= release_addr;
      uf_r <= 1'b0; ff_r <= 1'b0; bf_r <= 1'b0;
      lf_r <= 1'b0; rf_r <= 1'b0; ef_r <= 1'b0;
    end else begin
      if (scan_u_r) begin
        if (!uvl && !ef_r) begin
          ef_r <= 1'b1;
          uslot_r <= ui;
        end
        if (uvl && ust == addr_r && !uf_r) begin
          uf_r <= 1'b1;
          uhit_r <= ui;
          rlen_r <= {1'b0, ulen} + 1'b1;
          rend_r <= {1'b0, addr_r} + {1'b0, ulen} + 1'b1;
        end
      end
      if (scan_f_r) begin
        if (!cv && !ff_r) begin
          ff_r <= 1'b1;
          fslot_r <= fi;
        end
        if (cv && clen >= need && better) begin
          bf_r <= 1'b1;
          best_r <= fi;
          bstart_r <= cst;
          blen_r <= clen;
        end
        if (cv && !lf_r && ({1'b0, cst} + clen) == {1'b0, addr_r}) begin
          lf_r <= 1'b1;
          left_r <= fi;
          left_len_r <= clen;
        end
        if (cv && !rf_r && {1'b0, cst} == rend_r) begin
          rf_r <= 1'b1;
          right_r <= fi;
          right_len_r <= clen;
        end
      end
    end
  end

  // Table writes; during reset entry zero is loaded with the whole memory.
  always_comb begin
    fs_we = 1'b0;
    fl_we = 1'b0;
    u_we = 1'b0;
    f_wa = '0;
    fs_wd = '0;
    fl_wd = '0;
    if (!rst_n) begin
      fs_we = 1'b1;
      fl_we = 1'b1;
      fl_wd = LenW'(MemUnits);
    end else if (cmd.commit) begin
      if (func_r == FUNC_ALLOC) begin
        if (bf_r && ef_r) begin
          u_we = 1'b1;
          if (blen_r != need) begin
            fl_we = 1'b1;
            f_wa = best_r;
            fl_wd = nlen;
          end
        end
      end else if (uf_r) begin
        if (!lf_r && !rf_r) begin
          if (ff_r) begin
            fs_we = 1'b1;
            fl_we = 1'b1;
            f_wa = fslot_r;
            fs_wd = addr_r;
            fl_wd = rlen_r;
          end
        end else if (lf_r && rf_r) begin
          fl_we = 1'b1;
          f_wa = left_r;
          fl_wd = left_len_r + rlen_r + right_len_r;
        end else if (lf_r) begin
          fl_we = 1'b1;
          f_wa = left_r;
          fl_wd = left_len_r + rlen_r;
        end else begin
          fs_we = 1'b1;
          fl_we = 1'b1;
          f_wa = right_r;
          fs_wd = addr_r;
          fl_wd = right_len_r + rlen_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= FreeEntries'(1);
      uv_r <= '0;
      status_r <= ST_OK;
      gaddr_r <= '0;
    end else if (cmd.commit) begin
      gaddr_r <= '0;
      status_r <= ST_OK;
      if (func_r == FUNC_ALLOC) begin
        if (!bf_r) status_r <= ST_NOFIT;
        else if (!ef_r) status_r <= ST_FULL;
        else begin
          uv_r[uslot_r] <= 1'b1;
          if (blen_r == need) fv_r[best_r] <= 1'b0;
          gaddr_r <= galloc;
        end
      end else begin
        if (!uf_r) status_r <= ST_NOADDR;
        else if (!lf_r && !rf_r && !ff_r) status_r <= ST_FULL;
        else begin
          uv_r[uhit_r] <= 1'b0;
          if (!lf_r && !rf_r) fv_r[fslot_r] <= 1'b1;
          else if (lf_r && rf_r) fv_r[right_r] <= 1'b0;
        end
      end
    end
  end

  assign stat.status = status_r;
  assign stat.addr = gaddr_r;
endmodule

// Generic single-port-write RAM with registered read.
module vpa_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0] wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0] rdata_r
);
  logic [W-1:0] mem_r [D];

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata_r <= mem_r[raddr];
  end
endmodule

@@ design/variable_partition_allocator.sv @@
// Top level of the variable partition allocator.
// Each transaction (allocate or release) scans the used table and then the free table, one
// entry per cycle, then waits in a drain state for the last table read to return and commits;
// the result is then presented, one transaction at a time. The result is held until taken;
// the next transaction is accepted in the cycle after that.
module variable_partition_allocator (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [1:0] cfg_wdata,
  vpa_if.sink   in_if,
  vpa_if.source out_if
);
  import vpa_pkg::*;
  logic [1:0] strategy_r;
  vpa_cmd_t cmd;
  vpa_stat_t stat;
  logic in_ready, out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) strategy_r <= STRAT_FIRST;
    else if (cfg_we) strategy_r <= cfg_wdata;
  end

  vpa_ctrl u_ctrl (
    .clk, .rst_n,
    .in_fire(in_if.valid && in_if.ready),
    .out_fire(out_if.valid && out_if.ready),
    .in_ready, .out_valid, .cmd
  );

  vpa_dp u_dp (
    .clk, .rst_n, .cmd,
    .strategy(strategy_r),
    .func(in_if.data[2*AddrW]),
    .req_size(in_if.data[2*AddrW-1:AddrW]),
    .release_addr(in_if.data[AddrW-1:0]),
    .stat
  );

  assign in_if.ready = in_ready;
  assign out_if.valid = out_valid;
  assign out_if.data = {stat.addr, stat.status};
endmodule

@@ design/vpa_checker.sv @@
// Port-level checker for the allocator, bound to the top level.
module vpa_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [10:0] out_data
);
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready while result pending");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("second transaction accepted");
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data[1:0] != 2'd0) |-> out_data[10:2] == 9'd0)
    else $error("address nonzero on failure");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_data)) else $error("result changed");
endmodule

bind variable_partition_allocator vpa_checker u_vpa_checker (
  .clk, .rst_n,
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_data(out_if.data)
);

@@ tb/tb_variable_partition_allocator.sv @@
// Self-checking testbench of the variable partition allocator with its own fit predictor.
module tb_variable_partition_allocator;
  import vpa_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam int DrainCycles = 160;

  typedef struct {
    logic func;
    logic [8:0] size;
    logic [8:0] addr;
    bit pick_live;
  } alloc_op_t;

  typedef struct {
    logic [8:0] addr;
    logic [1:0] status;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_wdata = 2'd0;

  vpa_if #(.W(19)) in_ch ();
  vpa_if #(.W(11)) out_ch ();

  variable_partition_allocator DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_if(in_ch),
    .out_if(out_ch)
  );

  int seg_start [FreeEntries];
  int seg_len [FreeEntries];
  bit seg_valid [FreeEntries];
  int blk_start [UsedEntries];
  int blk_len [UsedEntries];
  bit blk_valid [UsedEntries];
  logic [1:0] fit_mode = STRAT_FIRST;

  alloc_op_t op_q[$];
  grant_t grant_q[$];
  int errors = 0;
  int cycles = 0;
  int send_gap = 0;
  int sink_stall = 0;
  bit calm = 1'b0;

  always #2 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  function automatic bit seg_better(int cand, int best);
    if (best < 0) return 1'b1;
    if (fit_mode == STRAT_BEST && seg_len[cand] != seg_len[best])
      return seg_len[cand] < seg_len[best];
    if (fit_mode == STRAT_WORST && seg_len[cand] != seg_len[best])
      return seg_len[cand] > seg_len[best];
    return seg_start[cand] < seg_start[best];
  endfunction

  function automatic grant_t predict_alloc(int size);
    grant_t g;
    int need;
    int best;
    int slot;
    need = size + 1;
    best = -1;
    slot = -1;
    g.addr = '0;
    g.status = ST_OK;
    for (int i = 0; i < FreeEntries; i++)
      if (seg_valid[i] && seg_len[i] >= need && seg_better(i, best)) best = i;
    if (best < 0) begin
      g.status = ST_NOFIT;
      return g;
    end
    for (int i = UsedEntries - 1; i >= 0; i--)
      if (!blk_valid[i]) slot = i;
    if (slot < 0) begin
      g.status = ST_FULL;
      return g;
    end
    if (seg_len[best] == need) begin
      g.addr = 9'(seg_start[best]);
      seg_valid[best] = 1'b0;
    end else begin
      seg_len[best] -= need;
      g.addr = 9'(seg_start[best] + seg_len[best]);
    end
    blk_valid[slot] = 1'b1;
    blk_start[slot] = int'(g.addr);
    blk_len[slot] = size;
    return g;
  endfunction

  function automatic grant_t predict_release(int addr);
    grant_t g;
    int u;
    int lft;
    int rgt;
    int slot;
    int len;
    u = -1;
    lft = -1;
    rgt = -1;
    slot = -1;
    g.addr = '0;
    g.status = ST_OK;
    for (int i = UsedEntries - 1; i >= 0; i--)
      if (blk_valid[i] && blk_start[i] == addr) u = i;
    if (u < 0) begin
      g.status = ST_NOADDR;
      return g;
    end
    len = blk_len[u] + 1;
    for (int i = 0; i < FreeEntries; i++) begin
      if (seg_valid[i] && lft < 0 && seg_start[i] + seg_len[i] == addr) lft = i;
      if (seg_valid[i] && rgt < 0 && seg_start[i] == addr + len) rgt = i;
    end
    if (lft < 0 && rgt < 0) begin
      for (int i = FreeEntries - 1; i >= 0; i--)
        if (!seg_valid[i]) slot = i;
      if (slot < 0) begin
        g.status = ST_FULL;
        return g;
      end
      seg_valid[slot] = 1'b1;
      seg_start[slot] = addr;
      seg_len[slot] = len;
    end else if (lft >= 0 && rgt >= 0) begin
      seg_len[lft] += len + seg_len[rgt];
      seg_valid[rgt] = 1'b0;
    end else if (lft >= 0) begin
      seg_len[lft] += len;
    end else begin
      seg_start[rgt] = addr;
      seg_len[rgt] += len;
    end
    blk_valid[u] = 1'b0;
    return g;
  endfunction

  function automatic logic [8:0] live_addr();
    int picks[$];
    for (int i = 0; i < UsedEntries; i++)
      if (blk_valid[i]) picks.push_back(blk_start[i]);
    if (picks.size() == 0) return 9'($urandom_range(0, 511));
    return 9'(picks[$urandom_range(0, picks.size() - 1)]);
  endfunction

  function automatic int draw_gap();
    if (calm) return 0;
    return $urandom_range(0, 19);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic load_next();
    alloc_op_t op;
    op = op_q.pop_front();
    if (op.pick_live) op.addr = live_addr();
    in_ch.data <= {op.func, op.size, op.addr};
    in_ch.valid <= 1'b1;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else if (in_ch.valid && in_ch.ready) begin
      if (in_ch.data[18] == FUNC_ALLOC)
        grant_q.push_back(predict_alloc(int'(in_ch.data[17:9])));
      else
        grant_q.push_back(predict_release(int'(in_ch.data[8:0])));
      send_gap = draw_gap();
      if (send_gap == 0 && op_q.size() > 0) load_next();
      else in_ch.valid <= 1'b0;
    end else if (!in_ch.valid) begin
      if (send_gap > 0) send_gap = send_gap - 1;
      else if (op_q.size() > 0) load_next();
    end
  end

  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (grant_q.size() == 0) begin
          report_mismatch("unexpected transaction", int'(out_ch.data), 0);
        end else begin
          want = grant_q.pop_front();
          if (out_ch.data[1:0] != want.status)
            report_mismatch("status", int'(out_ch.data[1:0]), int'(want.status));
          if (out_ch.data[10:2] != want.addr)
            report_mismatch("granted_addr", int'(out_ch.data[10:2]), int'(want.addr));
        end
        sink_stall = calm ? 0 : $urandom_range(0, 19);
      end else if (sink_stall > 0) begin
        sink_stall = sink_stall - 1;
      end
      out_ch.ready <= (sink_stall == 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[variable_partition_allocator] ERROR");
      $finish;
    end
  end

  task automatic push_op(logic func, int size, int addr, bit pick_live);
    alloc_op_t op;
    op.func = func;
    op.size = 9'(size);
    op.addr = 9'(addr);
    op.pick_live = pick_live;
    op_q.push_back(op);
  endtask

  task automatic wait_idle();
    wait (op_q.size() == 0 && !in_ch.valid && grant_q.size() == 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_mode(logic [1:0] m);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    fit_mode = m;
  endtask

  task automatic fill_random(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 45) push_op(FUNC_ALLOC, $urandom_range(0, 40), $urandom_range(0, 511), 0);
      else if (k < 50) push_op(FUNC_ALLOC, $urandom_range(0, 511), $urandom_range(0, 511), 0);
      else if (k < 90) push_op(FUNC_RELEASE, $urandom_range(0, 511), 0, 1);
      else push_op(FUNC_RELEASE, $urandom_range(0, 511), $urandom_range(0, 511), 0);
    end
  endtask

  initial begin
    logic [1:0] modes [6];
    modes = '{STRAT_BEST, STRAT_WORST, 2'd3, STRAT_FIRST, STRAT_WORST, STRAT_BEST};
    for (int i = 0; i < FreeEntries; i++) begin
      seg_valid[i] = 1'b0;
      seg_start[i] = 0;
      seg_len[i] = 0;
    end
    for (int i = 0; i < UsedEntries; i++) begin
      blk_valid[i] = 1'b0;
      blk_start[i] = 0;
      blk_len[i] = 0;
    end
    seg_valid[0] = 1'b1;
    seg_len[0] = MemUnits;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    push_op(FUNC_ALLOC, 511, 0, 0);
    push_op(FUNC_ALLOC, 0, 0, 0);
    push_op(FUNC_RELEASE, 0, 5, 0);
    push_op(FUNC_RELEASE, 0, 0, 0);
    push_op(FUNC_RELEASE, 0, 0, 0);
    push_op(FUNC_ALLOC, 0, 0, 0);
    push_op(FUNC_RELEASE, 511, 511, 0);
    push_op(FUNC_ALLOC, 100, 0, 0);
    push_op(FUNC_ALLOC, 200, 0, 0);
    push_op(FUNC_ALLOC, 50, 0, 0);
    push_op(FUNC_ALLOC, 300, 0, 0);
    push_op(FUNC_RELEASE, 0, 411, 0);
    push_op(FUNC_RELEASE, 0, 160, 0);
    push_op(FUNC_RELEASE, 0, 210, 0);
    push_op(FUNC_ALLOC, 0, 0, 0);
    push_op(FUNC_RELEASE, 0, 0, 1);
    push_op(FUNC_RELEASE, 0, 0, 1);
    push_op(FUNC_RELEASE, 0, 0, 1);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      set_mode(modes[p]);
      calm = (p == 3);
      if (p == 1) begin
        for (int i = 0; i < 66; i++) push_op(FUNC_ALLOC, $urandom_range(0, 5), 0, 0);
        for (int i = 0; i < 40; i++) push_op(FUNC_RELEASE, 0, 0, 1);
      end
      fill_random(260);
      wait_idle();
    end

    if (errors == 0) $display("[variable_partition_allocator] OK");
    else $display("[variable_partition_allocator] ERROR");
    $finish;
  end
endmodule

@@ files.f @@
design/vpa_pkg.sv
design/vpa_if.sv
design/vpa_ctrl.sv
design/vpa_dp.sv
design/variable_partition_allocator.sv
design/vpa_checker.sv
tb/tb_variable_partition_allocator.sv
